### design/odo_pkg.sv
// ----------------------------------------------------------------------------
// odo_pkg
// Shared types, constants and helper functions of the wheel odometry block.
// ----------------------------------------------------------------------------
package odo_pkg;

    localparam int CNT_W = 32;            // encoder count width
    localparam int DPT_W = 32;            // distance per tick register width
    localparam int WB_W  = 28;            // wheelbase register width
    localparam int US_W  = 32;            // elapsed time width
    localparam int POS_W = 64;            // position width
    localparam int ANG_W = 32;            // binary angle width
    localparam int SPD_W = 32;            // speed width

    localparam int MA_W  = 128;           // multiplicand / product width
    localparam int MB_W  = 64;            // multiplier width
    localparam int DN_W  = 128;           // dividend / quotient width
    localparam int DD_W  = 64;            // divisor width
    localparam int CR_W  = 34;            // CORDIC datapath width
    localparam int CR_N  = 30;            // CORDIC iterations

    localparam logic [31:0] TURN_SCALE  = 32'd683565276;
    localparam logic [31:0] US_PER_S    = 32'd1000000;
    localparam logic [CR_W-1:0] CR_GAIN = CR_W'(652032874);
    localparam logic [DPT_W-1:0] DPT_RST = DPT_W'(10385987);
    localparam logic [WB_W-1:0]  WB_RST  = WB_W'(4546626);

    // Configuration register indexes
    localparam logic CFG_DPT = 1'b0;
    localparam logic CFG_WB  = 1'b1;

    // Datapath operations, one per controller step
    typedef enum logic [4:0] {
        OP_DMAG, OP_WMAG, OP_COR1, OP_SX, OP_SY,
        OP_TURN, OP_DTH, OP_COR2,
        OP_XP1, OP_XP2, OP_XDIV, OP_YP1, OP_YP2, OP_YDIV,
        OP_VLIN1, OP_VLIN2, OP_VDEN, OP_VANG1, OP_VANG2,
        OP_PUB
    } t_op;

    typedef struct packed {
        logic load;
        logic start;
        logic publish;
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic done;
        logic straight;
        logic no_time;
        logic out_free;
    } t_sts;

    // Arctangent table for CORDIC, binary angle with full turn = 2^32
    function automatic logic [CR_W-1:0] atan_lut(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003;
            5'd29: v = 32'h00000001;
            default: v = 32'h0;
        endcase
        return {2'b00, v};
    endfunction

    // Clamp a magnitude to a signed 64-bit field, then apply the sign
    function automatic logic [POS_W-1:0] sat64(input logic [MA_W-1:0] mag, input logic neg);
        logic [MA_W-1:0]  lim;
        logic [POS_W-1:0] m;
        lim = {64'b0, neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF};
        m = (mag > lim) ? lim[POS_W-1:0] : mag[POS_W-1:0];
        return neg ? (POS_W'(0) - m) : m;
    endfunction

    // Clamp a magnitude to a signed 32-bit field, then apply the sign
    function automatic logic [SPD_W-1:0] sat32(input logic [MA_W-1:0] mag, input logic neg);
        logic [MA_W-1:0]  lim;
        logic [SPD_W-1:0] m;
        lim = {96'b0, neg ? 32'h8000_0000 : 32'h7FFF_FFFF};
        m = (mag > lim) ? lim[SPD_W-1:0] : mag[SPD_W-1:0];
        return neg ? (SPD_W'(0) - m) : m;
    endfunction

endpackage

### design/differential_drive_odometry.sv
// One item at a time: a new item is accepted only after the last result is published.
// Cost is set by the bit-serial multiplier, the restoring divider and the 30-step CORDIC.
// Reset (synchronous, active low): pose and stored counts clear, registers to defaults.
// ----------------------------------------------------------------------------
// differential_drive_odometry
// Two-wheel dead-reckoning odometry: pose, heading and speeds per encoder item.
// ----------------------------------------------------------------------------
module differential_drive_odometry
    import odo_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic signed [CNT_W-1:0] i_left_count,
    input  logic signed [CNT_W-1:0] i_right_count,
    input  logic [US_W-1:0]         i_elapsed_us,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [POS_W-1:0] o_pos_x,
    output logic signed [POS_W-1:0] o_pos_y,
    output logic signed [ANG_W-1:0] o_heading,
    output logic signed [SPD_W-1:0] o_linear_speed,
    output logic signed [SPD_W-1:0] o_angular_speed,
    output logic                    o_no_time_flag,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic                    i_cfg_index,
    input  logic [DPT_W-1:0]        i_cfg_data
);

    t_cmd w_cmd;
    t_sts w_sts;

    // Sequencer
    odo_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    // Arithmetic and storage
    odo_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_left_count    (i_left_count),
        .i_right_count   (i_right_count),
        .i_elapsed_us    (i_elapsed_us),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_pos_x         (o_pos_x),
        .o_pos_y         (o_pos_y),
        .o_heading       (o_heading),
        .o_linear_speed  (o_linear_speed),
        .o_angular_speed (o_angular_speed),
        .o_no_time_flag  (o_no_time_flag)
    );

endmodule

### design/odo_mul.sv
// ----------------------------------------------------------------------------
// odo_mul
// Bit-serial shift-add multiplier: 128-bit multiplicand, 64-bit multiplier,
// one multiplier bit per cycle, product truncated to 128 bits.
// ----------------------------------------------------------------------------
module odo_mul
    import odo_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [MA_W-1:0] i_a,
    input  logic [MB_W-1:0] i_b,
    output logic            o_done,
    output logic [MA_W-1:0] o_p
);

    logic [MA_W-1:0]          r_a, r_p;
    logic [MB_W-1:0]          r_b;
    logic [$clog2(MB_W)-1:0]  r_cnt;
    logic                     r_busy, r_done;

    // Control: count multiplier bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == ($clog2(MB_W))'(MB_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: add shifted multiplicand where the multiplier bit is set
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
            r_p <= '0;
        end else if (r_busy) begin
            if (r_b[0]) begin
                r_p <= r_p + r_a;
            end
            r_a <= r_a << 1;
            r_b <= r_b >> 1;
        end
    end

    assign o_done = r_done;
    assign o_p    = r_p;

endmodule

### design/odo_div.sv
// ----------------------------------------------------------------------------
// odo_div
// Restoring divider: 128-bit dividend, 64-bit divisor, one quotient bit per
// cycle, truncating quotient.
// ----------------------------------------------------------------------------
module odo_div
    import odo_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [DN_W-1:0] i_n,
    input  logic [DD_W-1:0] i_d,
    output logic            o_done,
    output logic [DN_W-1:0] o_q
);

    logic [DN_W-1:0]         r_n, r_q;
    logic [DD_W-1:0]         r_d, r_rem;
    logic [$clog2(DN_W)-1:0] r_cnt;
    logic                    r_busy, r_done;
    logic [DD_W:0]           w_trial;
    logic                    w_fit;

    // Shift in the next dividend bit and try the subtraction
    assign w_trial = {r_rem, r_n[DN_W-1]};
    assign w_fit   = (w_trial >= {1'b0, r_d});

    // Control: count quotient bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == ($clog2(DN_W))'(DN_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: one restoring step per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n   <= i_n;
            r_d   <= i_d;
            r_rem <= '0;
            r_q   <= '0;
        end else if (r_busy) begin
            r_n   <= r_n << 1;
            r_rem <= w_fit ? DD_W'(w_trial - {1'b0, r_d}) : w_trial[DD_W-1:0];
            r_q   <= {r_q[DN_W-2:0], w_fit};
        end
    end

    assign o_done = r_done;
    assign o_q    = r_q;

endmodule

### design/odo_cordic.sv
// ----------------------------------------------------------------------------
// odo_cordic
// Iterative rotation-mode CORDIC: sine and cosine in Q30 of a 32-bit binary
// angle, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module odo_cordic
    import odo_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [ANG_W-1:0]       i_angle,
    output logic                   o_done,
    output logic signed [CR_W-1:0] o_cos,
    output logic signed [CR_W-1:0] o_sin
);

    logic signed [CR_W-1:0] r_x, r_y, r_z;
    logic                   r_flip;
    logic [4:0]             r_cnt;
    logic                   r_busy, r_done;
    logic                   w_flip;
    logic [ANG_W-1:0]       w_ang, w_sum;
    logic signed [CR_W-1:0] w_xs, w_ys, w_at;

    // Fold the angle into the right half plane
    assign w_sum  = i_angle + 32'h4000_0000;
    assign w_flip = w_sum[ANG_W-1];
    assign w_ang  = w_flip ? (i_angle + 32'h8000_0000) : i_angle;

    assign w_xs = r_x >>> r_cnt;
    assign w_ys = r_y >>> r_cnt;
    assign w_at = signed'(atan_lut(r_cnt));

    // Control: count micro-rotations
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == 5'(CR_N - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: rotate toward zero residual angle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= signed'(CR_GAIN);
            r_y    <= '0;
            r_z    <= signed'({{(CR_W-ANG_W){w_ang[ANG_W-1]}}, w_ang});
            r_flip <= w_flip;
        end else if (r_busy) begin
            if (!r_z[CR_W-1]) begin
                r_x <= r_x - w_ys;
                r_y <= r_y + w_xs;
                r_z <= r_z - w_at;
            end else begin
                r_x <= r_x + w_ys;
                r_y <= r_y - w_xs;
                r_z <= r_z + w_at;
            end
        end
    end

    assign o_done = r_done;
    assign o_cos  = r_flip ? -r_x : r_x;
    assign o_sin  = r_flip ? -r_y : r_y;

endmodule

### design/odo_ctrl.sv
// ----------------------------------------------------------------------------
// odo_ctrl
// Sequencer: steps the datapath through the straight or arc update and the
// speed computation, one arithmetic operation at a time.
// ----------------------------------------------------------------------------
module odo_ctrl
    import odo_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT, S_PUB} t_state;

    t_state r_state;
    t_op    r_op, n_op;

    // Pick the operation that follows the current one
    always_comb begin
        n_op = OP_PUB;
        unique case (r_op) inside
            OP_DMAG:  n_op = OP_WMAG;
            OP_WMAG:  n_op = OP_COR1;
            OP_COR1:  n_op = i_sts.straight ? OP_SX : OP_TURN;
            OP_SX:    n_op = OP_SY;
            OP_TURN:  n_op = OP_DTH;
            OP_DTH:   n_op = OP_COR2;
            OP_COR2:  n_op = OP_XP1;
            OP_XP1:   n_op = OP_XP2;
            OP_XP2:   n_op = OP_XDIV;
            OP_XDIV:  n_op = OP_YP1;
            OP_YP1:   n_op = OP_YP2;
            OP_YP2:   n_op = OP_YDIV;
            OP_SY, OP_YDIV: n_op = i_sts.no_time ? OP_PUB : OP_VLIN1;
            OP_VLIN1: n_op = OP_VLIN2;
            OP_VLIN2: n_op = OP_VDEN;
            OP_VDEN:  n_op = OP_VANG1;
            OP_VANG1: n_op = OP_VANG2;
            OP_VANG2: n_op = OP_PUB;
            OP_PUB:   n_op = OP_PUB;
            default:  n_op = OP_PUB;
        endcase
    end

    // Drive commands from the current step
    always_comb begin
        o_ready       = (r_state == S_IDLE);
        o_cmd.load    = (r_state == S_IDLE) && i_valid;
        o_cmd.start   = (r_state == S_ISSUE);
        o_cmd.publish = (r_state == S_PUB) && i_sts.out_free;
        o_cmd.op      = r_op;
    end

    // Hold state and current operation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_DMAG;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= S_ISSUE;
                        r_op    <= OP_DMAG;
                    end
                end
                S_ISSUE: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (i_sts.done) begin
                        r_op    <= n_op;
                        r_state <= (n_op == OP_PUB) ? S_PUB : S_ISSUE;
                    end
                end
                S_PUB: begin
                    if (i_sts.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

### design/odo_dp.sv
// ----------------------------------------------------------------------------
// odo_dp
// Datapath: configuration and pose registers, working registers, the shared
// multiplier, divider and CORDIC, and the output register.
// ----------------------------------------------------------------------------
module odo_dp
    import odo_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    output t_sts                    o_sts,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic                    i_cfg_index,
    input  logic [DPT_W-1:0]        i_cfg_data,
    input  logic signed [CNT_W-1:0] i_left_count,
    input  logic signed [CNT_W-1:0] i_right_count,
    input  logic [US_W-1:0]         i_elapsed_us,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [POS_W-1:0] o_pos_x,
    output logic signed [POS_W-1:0] o_pos_y,
    output logic signed [ANG_W-1:0] o_heading,
    output logic signed [SPD_W-1:0] o_linear_speed,
    output logic signed [SPD_W-1:0] o_angular_speed,
    output logic                    o_no_time_flag
);

    // Configuration and persistent state
    logic [DPT_W-1:0] r_dpt;
    logic [WB_W-1:0]  r_wb;
    logic [CNT_W-1:0] r_prev_l, r_prev_r;
    logic [POS_W-1:0] r_x, r_y;
    logic [ANG_W-1:0] r_th;

    // Working registers
    logic [CNT_W:0]         r_smag, r_dmag_t;
    logic                   r_dneg, r_wneg, r_tneg;
    logic [US_W-1:0]        r_us;
    logic [63:0]            r_dmag, r_wmag, r_den;
    logic signed [CR_W-1:0] r_c1, r_s1, r_c2, r_s2;
    logic [ANG_W-1:0]       r_t2;
    logic [MA_W-1:0]        r_tmp;
    logic [SPD_W-1:0]       r_lin, r_ang;

    // Output register
    logic                   r_ovalid;
    logic [POS_W-1:0]       r_ox, r_oy;
    logic [ANG_W-1:0]       r_oth;
    logic [SPD_W-1:0]       r_olin, r_oang;
    logic                   r_oflag;

    // Unit interfaces
    logic                   w_mstart, w_dstart, w_cstart;
    logic                   w_mdone, w_ddone, w_cdone;
    logic [MA_W-1:0]        w_ma, w_p;
    logic [MB_W-1:0]        w_mb;
    logic [DN_W-1:0]        w_dn, w_q;
    logic [DD_W-1:0]        w_dd;
    logic [ANG_W-1:0]       w_cang;
    logic signed [CR_W-1:0] w_cos, w_sin;
    logic                   w_done;

    // Load-time deltas
    logic [CNT_W-1:0]       w_dl, w_dr;
    logic signed [CNT_W:0]  w_sum, w_dif;

    // Trig magnitudes and differences
    logic [WB_W-1:0]        w_wb;
    logic                   w_c1neg, w_s1neg;
    logic [CR_W-1:0]        w_c1mag, w_s1mag;
    logic signed [CR_W:0]   w_sd, w_cd;
    logic [CR_W:0]          w_sdmag, w_cdmag;
    logic [ANG_W-1:0]       w_dth;

    function automatic logic [ANG_W-1:0] w_wneg_dth(input logic [ANG_W-1:0] v, input logic n);
        return n ? (ANG_W'(0) - v) : v;
    endfunction

    assign w_wb = (r_wb == '0) ? WB_W'(1) : r_wb;

    assign w_dl  = i_left_count - r_prev_l;
    assign w_dr  = i_right_count - r_prev_r;
    assign w_sum = signed'({w_dl[CNT_W-1], w_dl}) + signed'({w_dr[CNT_W-1], w_dr});
    assign w_dif = signed'({w_dr[CNT_W-1], w_dr}) - signed'({w_dl[CNT_W-1], w_dl});

    assign w_c1neg = r_c1[CR_W-1];
    assign w_s1neg = r_s1[CR_W-1];
    assign w_c1mag = w_c1neg ? CR_W'(-r_c1) : CR_W'(r_c1);
    assign w_s1mag = w_s1neg ? CR_W'(-r_s1) : CR_W'(r_s1);
    assign w_sd    = {r_s2[CR_W-1], r_s2} - {r_s1[CR_W-1], r_s1};
    assign w_cd    = {r_c1[CR_W-1], r_c1} - {r_c2[CR_W-1], r_c2};
    assign w_sdmag = w_sd[CR_W] ? (CR_W+1)'(-w_sd) : (CR_W+1)'(w_sd);
    assign w_cdmag = w_cd[CR_W] ? (CR_W+1)'(-w_cd) : (CR_W+1)'(w_cd);
    assign w_dth   = w_wneg_dth(w_q[47:16], r_wneg);

    // Select unit operands for the current operation
    always_comb begin
        w_mstart = 1'b0;
        w_dstart = 1'b0;
        w_cstart = 1'b0;
        w_ma     = '0;
        w_mb     = '0;
        w_dn     = r_tmp;
        w_dd     = '0;
        w_cang   = r_th;
        unique case (i_cmd.op) inside
            OP_DMAG: begin
                w_mstart = i_cmd.start;
                w_ma = MA_W'(r_smag);
                w_mb = MB_W'(r_dpt);
            end
            OP_WMAG: begin
                w_mstart = i_cmd.start;
                w_ma = MA_W'(r_dmag_t);
                w_mb = MB_W'(r_dpt);
            end
            OP_COR1: begin
                w_cstart = i_cmd.start;
                w_cang = r_th;
            end
            OP_SX: begin
                w_mstart = i_cmd.start;
                w_ma = MA_W'(r_dmag);
                w_mb = MB_W'(w_c1mag);
            end
            OP_SY: begin
                w_mstart = i_cmd.start;
                w_ma = MA_W'(r_dmag);
                w_mb = MB_W'(w_s1mag);
            end
            OP_TURN: begin
                w_mstart = i_cmd.start;
                w_ma = MA_W'(r_wmag);
                w_mb = MB_W'(TURN_SCALE);
            end
            OP_DTH: begin
                w_dstart = i_cmd.start;
                w_dd = DD_W'(w_wb);
            end
            OP_COR2: begin
                w_cstart = i_cmd.start;
                w_cang = r_t2;
            end
            OP_XP1: begin
                w_mstart = i_cmd.start;
                w_ma = MA_W'(r_dmag);
                w_mb = MB_W'(w_sdmag);
            end
            OP_YP1: begin
                w_mstart = i_cmd.start;
                w_ma = MA_W'(r_dmag);
                w_mb = MB_W'(w_cdmag);
            end
            OP_XP2, OP_YP2: begin
                w_mstart = i_cmd.start;
                w_ma = r_tmp;
                w_mb = MB_W'(w_wb);
            end
            OP_XDIV, OP_YDIV: begin
                w_dstart = i_cmd.start;
                w_dd = r_wmag;
            end
            OP_VLIN1: begin
                w_mstart = i_cmd.start;
                w_ma = MA_W'(r_dmag);
                w_mb = MB_W'(US_PER_S);
            end
            OP_VLIN2: begin
                w_dstart = i_cmd.start;
                w_dd = {8'b0, r_us, 24'b0};
            end
            OP_VDEN: begin
                w_mstart = i_cmd.start;
                w_ma = MA_W'(w_wb);
                w_mb = MB_W'(r_us);
            end
            OP_VANG1: begin
                w_mstart = i_cmd.start;
                w_ma = MA_W'(r_wmag);
                w_mb = MB_W'(US_PER_S);
            end
            OP_VANG2: begin
                w_dstart = i_cmd.start;
                w_dd = r_den;
            end
            OP_PUB: begin
                w_mstart = 1'b0;
            end
            default: begin
                w_mstart = 1'b0;
            end
        endcase
    end

    odo_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mstart),
        .i_a     (w_ma),
        .i_b     (w_mb),
        .o_done  (w_mdone),
        .o_p     (w_p)
    );

    odo_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dstart),
        .i_n     (w_dn),
        .i_d     (w_dd),
        .o_done  (w_ddone),
        .o_q     (w_q)
    );

    odo_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cstart),
        .i_angle (w_cang),
        .o_done  (w_cdone),
        .o_cos   (w_cos),
        .o_sin   (w_sin)
    );

    assign w_done = w_mdone | w_ddone | w_cdone;

    // Configuration, pose and previous counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dpt    <= DPT_RST;
            r_wb     <= WB_RST;
            r_prev_l <= '0;
            r_prev_r <= '0;
            r_x      <= '0;
            r_y      <= '0;
            r_th     <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_DPT: r_dpt <= i_cfg_data;
                    CFG_WB:  r_wb  <= i_cfg_data[WB_W-1:0];
                    default: r_dpt <= r_dpt;
                endcase
            end
            if (i_cmd.load) begin
                r_prev_l <= i_left_count;
                r_prev_r <= i_right_count;
            end
            if (w_done) begin
                case (i_cmd.op)
                    OP_SX:   r_x <= r_x + sat64(w_p >> 30, r_dneg ^ w_c1neg);
                    OP_SY:   r_y <= r_y + sat64(w_p >> 30, r_dneg ^ w_s1neg);
                    OP_XDIV: r_x <= r_x + sat64(w_q, r_dneg ^ r_tneg ^ r_wneg);
                    OP_YDIV: begin
                        r_y  <= r_y + sat64(w_q, r_dneg ^ r_tneg ^ r_wneg);
                        r_th <= r_t2;
                    end
                    default: r_th <= r_th;
                endcase
            end
        end
    end

    // Working registers: capture deltas, then write back unit results
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dneg   <= w_sum[CNT_W];
            r_smag   <= w_sum[CNT_W] ? (CNT_W+1)'(-w_sum) : (CNT_W+1)'(w_sum);
            r_wneg   <= w_dif[CNT_W];
            r_dmag_t <= w_dif[CNT_W] ? (CNT_W+1)'(-w_dif) : (CNT_W+1)'(w_dif);
            r_us     <= i_elapsed_us;
            r_lin    <= '0;
            r_ang    <= '0;
        end
        if (w_done) begin
            case (i_cmd.op) inside
                OP_DMAG:  r_dmag <= w_p[64:1];
                OP_WMAG:  r_wmag <= w_p[63:0];
                OP_COR1: begin
                    r_c1 <= w_cos;
                    r_s1 <= w_sin;
                end
                OP_TURN:  r_tmp <= w_p;
                OP_DTH:   r_t2  <= r_th + w_dth;
                OP_COR2: begin
                    r_c2 <= w_cos;
                    r_s2 <= w_sin;
                end
                OP_XP1: begin
                    r_tmp  <= w_p;
                    r_tneg <= w_sd[CR_W];
                end
                OP_YP1: begin
                    r_tmp  <= w_p;
                    r_tneg <= w_cd[CR_W];
                end
                OP_XP2, OP_YP2: r_tmp <= w_p >> 14;
                OP_VLIN1, OP_VANG1: r_tmp <= w_p;
                OP_VLIN2: r_lin <= sat32(w_q, r_dneg);
                OP_VDEN:  r_den <= w_p[63:0];
                OP_VANG2: r_ang <= sat32(w_q, r_wneg);
                default:  r_tmp <= r_tmp;
            endcase
        end
    end

    // Output register: hold the item until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.publish) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            r_ox    <= r_x;
            r_oy    <= r_y;
            r_oth   <= r_th;
            r_olin  <= r_lin;
            r_oang  <= r_ang;
            r_oflag <= (r_us == '0);
        end
    end

    always_comb begin
        o_sts.done     = w_done;
        o_sts.straight = (r_wmag == '0);
        o_sts.no_time  = (r_us == '0);
        o_sts.out_free = !r_ovalid || i_ready;
    end

    assign o_cfg_ready     = 1'b1;
    assign o_valid         = r_ovalid;
    assign o_pos_x         = r_ox;
    assign o_pos_y         = r_oy;
    assign o_heading       = r_oth;
    assign o_linear_speed  = r_olin;
    assign o_angular_speed = r_oang;
    assign o_no_time_flag  = r_oflag;

endmodule

### tb/differential_drive_odometry_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// differential_drive_odometry_checker
// Watches the item, result and register channels of the odometry block,
// predicts pose, heading and speeds for each accepted item, and compares
// every accepted result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module differential_drive_odometry_checker
    import odo_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic                    i_ready_in,
    input  logic signed [CNT_W-1:0] i_left_count,
    input  logic signed [CNT_W-1:0] i_right_count,
    input  logic [US_W-1:0]         i_elapsed_us,
    input  logic                    i_out_valid,
    input  logic                    i_out_ready,
    input  logic signed [POS_W-1:0] i_pos_x,
    input  logic signed [POS_W-1:0] i_pos_y,
    input  logic signed [ANG_W-1:0] i_heading,
    input  logic signed [SPD_W-1:0] i_linear_speed,
    input  logic signed [SPD_W-1:0] i_angular_speed,
    input  logic                    i_no_time_flag,
    input  logic                    i_cfg_valid,
    input  logic                    i_cfg_ready,
    input  logic                    i_cfg_index,
    input  logic [DPT_W-1:0]        i_cfg_data,
    output int                      o_errors,
    output int                      o_pending
);

    typedef struct {
        logic [63:0] pos_x;
        logic [63:0] pos_y;
        logic [31:0] heading;
        logic [31:0] lin;
        logic [31:0] ang;
        logic        no_time;
    } t_pose;

    localparam longint ARCTAN_STEP [30] = '{
        'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
        'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
        'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D, 'h000028BE, 'h0000145F,
        'h00000A30, 'h00000518, 'h0000028C, 'h00000146, 'h000000A3, 'h00000051,
        'h00000029, 'h00000014, 'h0000000A, 'h00000005, 'h00000003, 'h00000001
    };

    // Predicted block state
    logic [31:0] tick_dist;
    logic [27:0] base_len;
    logic [31:0] last_left, last_right;
    logic [63:0] x_pos, y_pos;
    logic [31:0] theta;
    t_pose       pose_q[$];

    // Clamp a magnitude to a signed field of the given width, then apply sign
    function automatic logic [63:0] clamp_signed(logic [127:0] mag, bit neg, int bits);
        logic [127:0] lim;
        logic [63:0]  m;
        lim = (128'd1 << (bits - 1)) - (neg ? 128'd0 : 128'd1);
        m = (mag > lim) ? lim[63:0] : mag[63:0];
        return neg ? 64'd0 - m : m;
    endfunction

    // Q30 cosine and sine of a binary angle by CORDIC rotation
    function automatic void rotate(input logic [31:0] ang, output longint c, output longint s);
        bit     flip;
        longint x, y, z, xs, ys;
        flip = ang[31] ^ ang[30];
        if (flip) ang = ang + 32'h80000000;
        z = longint'($signed(ang));
        x = 652032874;
        y = 0;
        for (int i = 0; i < 30; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys; y = y + xs; z = z - ARCTAN_STEP[i];
            end else begin
                x = x + ys; y = y - xs; z = z + ARCTAN_STEP[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    // Position step along an arc: travel times trig difference over heading change
    function automatic logic [63:0] arc_offset(logic [63:0] dmag, bit dneg, longint trig,
                                               logic [63:0] wb, logic [63:0] wmag, bit wneg);
        bit           tneg;
        logic [63:0]  tmag;
        logic [127:0] num;
        tneg = trig < 0;
        tmag = tneg ? 64'(-trig) : 64'(trig);
        num = (128'(dmag) * tmag * wb) >> 14;
        return clamp_signed(num / wmag, dneg ^ tneg ^ wneg, 64);
    endfunction

    // Advance the predicted pose by one item and return the expected result
    function automatic t_pose advance_pose(logic [31:0] left, logic [31:0] right,
                                           logic [31:0] us);
        t_pose       p;
        longint      dl, dr, dsum, wdiff, c1, s1, c2, s2;
        bit          dneg, wneg, cneg, sneg;
        logic [63:0] dmag, wmag, wb, cm, sm;
        logic [31:0] dth, t2;
        dl = longint'($signed(left - last_left));
        dr = longint'($signed(right - last_right));
        wb = (base_len == 0) ? 64'd1 : 64'(base_len);
        dsum = dl + dr;
        dneg = dsum < 0;
        dmag = 64'((128'(dneg ? -dsum : dsum) * tick_dist) >> 1);
        wdiff = dr - dl;
        wneg = wdiff < 0;
        wmag = 64'(128'(wneg ? -wdiff : wdiff) * tick_dist);
        rotate(theta, c1, s1);
        if (dl == dr || wmag == 0) begin
            cneg = c1 < 0;
            sneg = s1 < 0;
            cm = cneg ? 64'(-c1) : 64'(c1);
            sm = sneg ? 64'(-s1) : 64'(s1);
            x_pos = x_pos + clamp_signed((128'(dmag) * cm) >> 30, dneg ^ cneg, 64);
            y_pos = y_pos + clamp_signed((128'(dmag) * sm) >> 30, dneg ^ sneg, 64);
        end else begin
            dth = 32'(((128'(wmag) * 128'd683565276) / wb) >> 16);
            if (wneg) dth = 32'd0 - dth;
            t2 = theta + dth;
            rotate(t2, c2, s2);
            x_pos = x_pos + arc_offset(dmag, dneg, s2 - s1, wb, wmag, wneg);
            y_pos = y_pos + arc_offset(dmag, dneg, c1 - c2, wb, wmag, wneg);
            theta = t2;
        end
        p.pos_x = x_pos;
        p.pos_y = y_pos;
        p.heading = theta;
        if (us == 0) begin
            p.lin = '0;
            p.ang = '0;
            p.no_time = 1'b1;
        end else begin
            p.lin = 32'(clamp_signed((128'(dmag) * 128'd1000000) / (128'(us) << 24),
                                     dneg, 32));
            p.ang = 32'(clamp_signed((128'(wmag) * 128'd1000000) / (128'(wb) * us),
                                     wneg, 32));
            p.no_time = 1'b0;
        end
        last_left = left;
        last_right = right;
        return p;
    endfunction

    // Track registers, predict on each accepted item, compare each accepted result
    always @(posedge i_clk) begin
        t_pose e;
        if (!i_rst_n) begin
            tick_dist = 32'd10385987;
            base_len = 28'd4546626;
            last_left = '0;
            last_right = '0;
            x_pos = '0;
            y_pos = '0;
            theta = '0;
            pose_q.delete();
            o_errors <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_DPT) tick_dist = i_cfg_data;
                else base_len = i_cfg_data[27:0];
            end
            if (i_out_valid && i_out_ready) begin
                if (pose_q.size() == 0) begin
                    $error("result with no item outstanding");
                    o_errors <= o_errors + 1;
                end else begin
                    e = pose_q.pop_front();
                    if (i_pos_x !== e.pos_x || i_pos_y !== e.pos_y || i_heading !== e.heading
                        || i_linear_speed !== e.lin || i_angular_speed !== e.ang
                        || i_no_time_flag !== e.no_time)
                        o_errors <= o_errors + 1;
                    if (i_pos_x !== e.pos_x)
                        $error("pos_x: expected %0d, got %0d", $signed(e.pos_x), i_pos_x);
                    if (i_pos_y !== e.pos_y)
                        $error("pos_y: expected %0d, got %0d", $signed(e.pos_y), i_pos_y);
                    if (i_heading !== e.heading)
                        $error("heading: expected %0d, got %0d", $signed(e.heading), i_heading);
                    if (i_linear_speed !== e.lin)
                        $error("linear_speed: expected %0d, got %0d", $signed(e.lin),
                               i_linear_speed);
                    if (i_angular_speed !== e.ang)
                        $error("angular_speed: expected %0d, got %0d", $signed(e.ang),
                               i_angular_speed);
                    if (i_no_time_flag !== e.no_time)
                        $error("no_time_flag: expected %0b, got %0b", e.no_time,
                               i_no_time_flag);
                end
            end
            if (i_valid && i_ready_in)
                pose_q.push_back(advance_pose(i_left_count, i_right_count, i_elapsed_us));
        end
        o_pending <= pose_q.size();
    end

endmodule

### tb/differential_drive_odometry_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// differential_drive_odometry_tb
// Drives encoder items and register writes into the odometry block under
// random sender and receiver stalls; a checker alongside predicts and compares.
// ----------------------------------------------------------------------------
module differential_drive_odometry_tb;
    import odo_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int LONG_HOLD   = 8000;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_ready;
    logic signed [CNT_W-1:0] i_left_count;
    logic signed [CNT_W-1:0] i_right_count;
    logic [US_W-1:0]         i_elapsed_us;
    logic                    o_valid;
    logic                    i_ready;
    logic signed [POS_W-1:0] o_pos_x;
    logic signed [POS_W-1:0] o_pos_y;
    logic signed [ANG_W-1:0] o_heading;
    logic signed [SPD_W-1:0] o_linear_speed;
    logic signed [SPD_W-1:0] o_angular_speed;
    logic                    o_no_time_flag;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic                    i_cfg_index;
    logic [DPT_W-1:0]        i_cfg_data;

    int          fail_count;
    int          outstanding;
    int          items_sent;
    int          idle_cycles;
    logic [31:0] cur_left, cur_right;

    differential_drive_odometry dut (.*);

    differential_drive_odometry_checker checker_i (
        .i_clk, .i_rst_n, .i_valid, .i_ready_in(o_ready),
        .i_left_count, .i_right_count, .i_elapsed_us,
        .i_out_valid(o_valid), .i_out_ready(i_ready),
        .i_pos_x(o_pos_x), .i_pos_y(o_pos_y), .i_heading(o_heading),
        .i_linear_speed(o_linear_speed), .i_angular_speed(o_angular_speed),
        .i_no_time_flag(o_no_time_flag),
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .o_errors(fail_count), .o_pending(outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Offer one item after a random gap; hold it until accepted
    task automatic send_item(input logic [31:0] left, input logic [31:0] right,
                             input logic [31:0] us);
        int pick;
        int gap;
        pick = $urandom_range(0, 99);
        gap = (pick < 40) ? 0 : (pick < 85) ? $urandom_range(1, 4) :
              (pick < 95) ? $urandom_range(5, 30) : $urandom_range(100, 400);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_left_count <= left;
        i_right_count <= right;
        i_elapsed_us <= us;
        cur_left = left;
        cur_right = right;
        @(negedge i_clk);
        while (!o_ready) @(negedge i_clk);
        @(posedge i_clk);
        items_sent++;
    endtask

    // Drain: hold the item channel idle until every result is in
    task automatic drain_results();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (outstanding != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // Write one register; the block is idle when this is called
    task automatic write_reg(input logic idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        while (!o_cfg_ready) @(negedge i_clk);
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Random motion: mostly smooth driving, some spins, jumps and stops
    task automatic random_item();
        int          kind;
        int          dl, dr;
        int          tsel;
        logic [31:0] us;
        kind = $urandom_range(0, 99);
        dl = $urandom_range(0, 6000) - 3000;
        dr = dl + $urandom_range(0, 600) - 300;
        tsel = $urandom_range(0, 99);
        us = (tsel < 10) ? 32'd0 : (tsel < 20) ? $urandom() :
             (tsel < 25) ? 32'd1 : $urandom_range(1000, 50000);
        if (kind < 55)
            send_item(cur_left + dl, cur_right + dr, us);
        else if (kind < 65)
            send_item(cur_left + dl, cur_right + dl, us);
        else if (kind < 73)
            send_item(cur_left, cur_right, us);
        else if (kind < 80)
            send_item($urandom(), $urandom(), us);
        else if (kind < 85)
            send_item(cur_left + ($urandom_range(0, 1) ? 32'h80000000 : 32'h7FFFFFFF),
                      cur_right - $urandom_range(0, 1), us);
        else if (kind < 95)
            send_item(cur_left + dl, cur_right - dl, us);
        else
            send_item(cur_left + $urandom_range(0, 200000) - 100000,
                      cur_right + $urandom_range(0, 200000) - 100000, us);
    endtask

    // Receiver: random stalls, one long hold-off once the sender is busy
    initial begin
        bit long_done;
        int pick;
        long_done = 0;
        i_ready = 1'b0;
        @(posedge i_clk);
        forever begin
            if (!long_done && items_sent >= 40) begin
                i_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                long_done = 1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
                i_ready <= 1'b1;
                repeat ($urandom_range(50, 3000)) @(posedge i_clk);
            end else if (pick < 85) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
                i_ready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
            end else begin
                i_ready <= 1'b0;
                repeat ($urandom_range(10, 200)) @(posedge i_clk);
                i_ready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
            end
        end
    end

    // Watchdog: count cycles with no handshake on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)
            || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Stimulus and verdict
    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_left_count = '0;
        i_right_count = '0;
        i_elapsed_us = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_DPT;
        i_cfg_data = '0;
        items_sent = 0;
        cur_left = '0;
        cur_right = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: defaults, no motion, straight, arcs, spin, jumps, zero time
        send_item(32'd0, 32'd0, 32'd0);
        send_item(32'd100, 32'd100, 32'd1000);
        send_item(32'd400, 32'd250, 32'd20000);
        send_item(32'd100, 32'd200, 32'd0);
        send_item(32'd1100, -32'sd800, 32'd1000);
        send_item(32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF);
        send_item(32'hFFFFFFFF, 32'h00000000, 32'd1);
        send_item(32'h80000000, 32'h7FFFFFFF, 32'd5000);
        send_item(32'h80000000, 32'h7FFFFFFF, 32'd5000);
        drain_results();

        // Zero distance per tick: straight with no travel
        write_reg(CFG_DPT, 32'd0);
        send_item(32'd5000, 32'd9000, 32'd1000);
        drain_results();
        // Zero wheelbase and widest travel
        write_reg(CFG_DPT, 32'hFFFFFFFF);
        write_reg(CFG_WB, 32'd0);
        send_item(32'd5001, 32'd9000, 32'd1);
        send_item(32'h85001000, 32'h09000000, 32'd7);
        drain_results();
        write_reg(CFG_WB, 32'hFFFFFFFF);
        send_item(32'h05001000, 32'h89000000, 32'd0);
        send_item(32'h05001100, 32'h89000300, 32'hFFFFFFFF);
        drain_results();
        write_reg(CFG_DPT, 32'd1);
        write_reg(CFG_WB, 32'd1);
        send_item(32'h05001200, 32'h89000100, 32'd3);
        send_item(32'h05001200, 32'h89000100, 32'd3);
        drain_results();

        // Random phases under several register settings
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin
                    write_reg(CFG_DPT, 32'd10385987);
                    write_reg(CFG_WB, 32'd4546626);
                end
                1: begin
                    write_reg(CFG_DPT, 32'hFFFFFFFF);
                    write_reg(CFG_WB, 32'd1);
                end
                2: begin
                    write_reg(CFG_DPT, $urandom_range(1, 100));
                    write_reg(CFG_WB, 32'h0FFFFFFF);
                end
                3: begin
                    write_reg(CFG_DPT, $urandom());
                    write_reg(CFG_WB, 32'd0);
                end
                default: begin
                    write_reg(CFG_DPT, $urandom());
                    write_reg(CFG_WB, $urandom());
                end
            endcase
            repeat (130) random_item();
            drain_results();
        end

        repeat (50) @(posedge i_clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
